[rtl/dpts_pkg.sv]
// ----------------------------------------------------------------------------
// dpts_pkg - direction to pan/tilt steps: shared constants
// Fixed-point widths, CORDIC arctangent table, conversion constants and
// configuration register indexes.
// ----------------------------------------------------------------------------
package dpts_pkg;

    localparam int IN_W       = 24;
    localparam int XY_W       = 34;
    localparam int ANG_W      = 34;
    localparam int C_W        = 36;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int HEAD_W     = 16;
    localparam int SPD_W      = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HEADING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_SPD      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_SPD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_LOWEST   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_HIGHEST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_LOWEST  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_HIGHEST = 3'd6;

    localparam logic [HEAD_W-1:0] RST_ZERO_HEADING = 16'd18000;
    localparam logic [SPD_W-1:0]  RST_PAN_SPD      = 24'd1274311;
    localparam logic [SPD_W-1:0]  RST_TILT_SPD     = 24'd5097245;
    localparam int                RST_PAN_LOWEST   = -3088;
    localparam int                RST_PAN_HIGHEST  = 3088;
    localparam int                RST_TILT_LOWEST  = -3510;
    localparam int                RST_TILT_HIGHEST = 2314;

    localparam logic               AXIS_PAN  = 1'b0;
    localparam logic               AXIS_TILT = 1'b1;

    localparam logic [31:0]        KINV_Q32     = 32'h9B74EDA8;
    localparam logic [31:0]        CD_SCALE     = 32'd36000;
    localparam logic [31:0]        RECIP_100    = 32'd687194768;
    localparam logic [31:0]        STEP_HALF    = 32'd50;
    localparam logic [47:0]        CD_HALF      = 48'd32768;
    localparam logic [63:0]        LEN_HALF     = 64'h0000_0000_8000_0000;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [C_W-1:0]   HALF_C       = 36'sd1179648000;
    localparam logic signed [C_W-1:0]   NEG_HALF_C   = -36'sd1179648000;
    localparam logic signed [C_W-1:0]   FULL_C       = 36'sd2359296000;

    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            5'd31: v = 32'h00000000;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

[rtl/direction_to_pan_tilt_steps_top.sv]
// ----------------------------------------------------------------------------
// direction_to_pan_tilt_steps_top - pan/tilt step commands from a direction
// Two CORDIC vectoring runs give bearing and elevation; both are scaled to
// motor steps, rounded, clamped and sent only when they change.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------
//   in       | i_in_valid / o_in_ready    | i_north, i_east, i_down
//   out      | o_out_valid / i_out_ready  | o_axis, o_position, o_last_of_run
//   cfg      | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// The two CORDIC runs share one shift-add datapath, and every product is
// formed by the single shared 32x32 multiplier.
// A zero vector skips its CORDIC run. One item is held at a time; the next
// input transfer is taken once the last result sits in the output register,
// or once the item has no command to send. Reset is synchronous; it
// restores the configuration and forgets the positions sent. A stalled
// output holds the sequencer before loading.
// ----------------------------------------------------------------------------
module direction_to_pan_tilt_steps_top
    import dpts_pkg::*;
#(
    parameter int CORDIC_STEPS  = 20,
    parameter int POSITION_BITS = 14
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [IN_W-1:0]          i_north,
    input  logic signed [IN_W-1:0]          i_east,
    input  logic signed [IN_W-1:0]          i_down,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_axis,
    output logic signed [POSITION_BITS-1:0] o_position,
    output logic                            o_last_of_run,
    input  logic                            i_cfg_we,
    input  logic [CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0]           i_cfg_data
);

    localparam int P_W    = POSITION_BITS;
    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_PRE, S_ITER, S_HMUL, S_HLOAD, S_CDMUL, S_CDRND, S_WRAPLO,
        S_WRAPHI, S_SMULLO, S_SMULHI, S_SACC, S_DMUL, S_DRES, S_DECIDE,
        S_OUTPAN, S_OUTTILT
    } t_state;

    t_state                  r_state;

    logic [HEAD_W-1:0]       r_zero_heading;
    logic [SPD_W-1:0]        r_pan_spd;
    logic [SPD_W-1:0]        r_tilt_spd;
    logic signed [P_W-1:0]   r_pan_lo;
    logic signed [P_W-1:0]   r_pan_hi;
    logic signed [P_W-1:0]   r_tilt_lo;
    logic signed [P_W-1:0]   r_tilt_hi;

    logic signed [XY_W-1:0]  r_x;
    logic signed [XY_W-1:0]  r_y;
    logic signed [ANG_W-1:0] r_z;
    logic signed [XY_W-1:0]  r_up;
    logic signed [ANG_W-1:0] r_bear;
    logic [STEP_W-1:0]       r_i;
    logic                    r_run;
    logic                    r_axis;
    logic                    r_neg;
    logic signed [C_W-1:0]   r_c;
    logic [C_W-1:0]          r_cmag;
    logic [41:0]             r_acc;
    logic [31:0]             r_t;
    logic [63:0]             r_prod;
    logic signed [P_W-1:0]   r_pan_step;
    logic signed [P_W-1:0]   r_tilt_step;
    logic                    r_tilt_go;
    logic signed [P_W-1:0]   r_sent_pan;
    logic signed [P_W-1:0]   r_sent_tilt;
    logic                    r_pan_known;
    logic                    r_tilt_known;

    logic                    r_out_valid;
    logic                    r_out_axis;
    logic signed [P_W-1:0]   r_out_pos;
    logic                    r_out_last;

    logic signed [XY_W-1:0]  north_ext;
    logic signed [XY_W-1:0]  east_ext;
    logic signed [XY_W-1:0]  down_ext;
    logic signed [XY_W-1:0]  dx;
    logic signed [XY_W-1:0]  dy;
    logic signed [ANG_W-1:0] atan_ext;
    logic                    y_pos;
    logic                    xy_zero;
    logic [XY_W-1:0]         len;
    logic [63:0]             horiz_sum;
    logic signed [ANG_W-1:0] ang_sel;
    logic [ANG_W-1:0]        ang_mag;
    logic [47:0]             cd_sum;
    logic [C_W-1:0]          cd_mag;
    logic signed [C_W-1:0]   cd;
    logic signed [C_W-1:0]   pan_c;
    logic [C_W-1:0]          c_mag;
    logic [SPD_W-1:0]        spd;
    logic [63:0]             step_total;
    logic [27:0]             q;
    logic signed [29:0]      p;
    logic signed [29:0]      lim_lo;
    logic signed [29:0]      lim_hi;
    logic signed [29:0]      p_lo;
    logic signed [29:0]      p_clamped;
    logic signed [P_W-1:0]   pos;
    logic                    pan_go;
    logic                    tilt_go;
    logic                    out_free;
    logic                    out_load;
    logic                    mul_en;
    logic [31:0]             mul_a;
    logic [31:0]             mul_b;

    assign north_ext = {{(XY_W - IN_W - 6){i_north[IN_W-1]}}, i_north, 6'b0};
    assign east_ext  = {{(XY_W - IN_W - 6){i_east[IN_W-1]}}, i_east, 6'b0};
    assign down_ext  = {{(XY_W - IN_W - 6){i_down[IN_W-1]}}, i_down, 6'b0};

    assign dx       = r_y >>> r_i;
    assign dy       = r_x >>> r_i;
    assign atan_ext = $signed({2'b00, atan_entry(5'(r_i))});
    assign y_pos    = !r_y[XY_W-1] && (r_y != '0);
    assign xy_zero  = (r_x == '0) && (r_y == '0);

    assign len       = r_x[XY_W-1] ? '0 : r_x;
    assign horiz_sum = r_prod + LEN_HALF;

    assign ang_sel = r_axis ? r_z : r_bear;
    assign ang_mag = ang_sel[ANG_W-1] ? ANG_W'(-ang_sel) : ang_sel;
    assign cd_sum  = r_prod[47:0] + CD_HALF;
    assign cd_mag  = C_W'(cd_sum[47:16]);
    assign cd      = r_neg ? -$signed(cd_mag) : $signed(cd_mag);
    assign pan_c   = $signed({4'b0, r_zero_heading, 16'b0}) - cd;

    assign c_mag      = r_c[C_W-1] ? C_W'(-r_c) : r_c;
    assign spd        = r_axis ? r_tilt_spd : r_pan_spd;
    assign step_total = 64'(r_acc) + {r_prod[45:0], 18'b0};

    assign q         = r_prod[63:36];
    assign p         = r_neg ? -$signed({2'b0, q}) : $signed({2'b0, q});
    assign lim_lo    = 30'(r_axis ? r_tilt_lo : r_pan_lo);
    assign lim_hi    = 30'(r_axis ? r_tilt_hi : r_pan_hi);
    assign p_lo      = (p < lim_lo) ? lim_lo : p;
    assign p_clamped = (p_lo > lim_hi) ? lim_hi : p_lo;
    assign pos       = p_clamped[P_W-1:0];

    assign pan_go   = !r_pan_known || (r_pan_step != r_sent_pan);
    assign tilt_go  = !r_tilt_known || (r_tilt_step != r_sent_tilt);
    assign out_free = !r_out_valid || i_out_ready;
    assign out_load = out_free && ((r_state == S_OUTPAN) || (r_state == S_OUTTILT));

    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (r_state)
            S_HMUL: begin
                mul_a = len[31:0];
                mul_b = KINV_Q32;
            end
            S_CDMUL: begin
                mul_a = ang_mag[31:0];
                mul_b = CD_SCALE;
            end
            S_SMULLO: begin
                mul_a = 32'(c_mag[17:0]);
                mul_b = 32'(spd);
            end
            S_SMULHI: begin
                mul_a = 32'(r_cmag[35:18]);
                mul_b = 32'(spd);
            end
            S_DMUL: begin
                mul_a = r_t;
                mul_b = RECIP_100;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_heading <= RST_ZERO_HEADING;
            r_pan_spd      <= RST_PAN_SPD;
            r_tilt_spd     <= RST_TILT_SPD;
            r_pan_lo       <= P_W'(RST_PAN_LOWEST);
            r_pan_hi       <= P_W'(RST_PAN_HIGHEST);
            r_tilt_lo      <= P_W'(RST_TILT_LOWEST);
            r_tilt_hi      <= P_W'(RST_TILT_HIGHEST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ZERO_HEADING: r_zero_heading <= i_cfg_data[HEAD_W-1:0];
                CFG_PAN_SPD:      r_pan_spd      <= i_cfg_data[SPD_W-1:0];
                CFG_TILT_SPD:     r_tilt_spd     <= i_cfg_data[SPD_W-1:0];
                CFG_PAN_LOWEST:   r_pan_lo       <= i_cfg_data[P_W-1:0];
                CFG_PAN_HIGHEST:  r_pan_hi       <= i_cfg_data[P_W-1:0];
                CFG_TILT_LOWEST:  r_tilt_lo      <= i_cfg_data[P_W-1:0];
                CFG_TILT_HIGHEST: r_tilt_hi      <= i_cfg_data[P_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_pan_known  <= 1'b0;
            r_tilt_known <= 1'b0;
            r_sent_pan   <= '0;
            r_sent_tilt  <= '0;
        end else begin
            if (r_out_valid && i_out_ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_x     <= north_ext;
                        r_y     <= east_ext;
                        r_up    <= -down_ext;
                        r_run   <= 1'b0;
                        r_axis  <= AXIS_PAN;
                        r_state <= S_PRE;
                    end
                end
                S_PRE: begin
                    r_i <= '0;
                    if (xy_zero) begin
                        r_z     <= '0;
                        r_state <= r_run ? S_CDMUL : S_HMUL;
                    end else begin
                        if (r_x[XY_W-1]) begin
                            if (!r_y[XY_W-1]) begin
                                r_x <= r_y;
                                r_y <= -r_x;
                                r_z <= QUARTER_TURN;
                            end else begin
                                r_x <= -r_y;
                                r_y <= r_x;
                                r_z <= -QUARTER_TURN;
                            end
                        end else begin
                            r_z <= '0;
                        end
                        r_state <= S_ITER;
                    end
                end
                S_ITER: begin
                    if (y_pos) begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + atan_ext;
                    end else begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - atan_ext;
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == LAST_STEP) begin
                        r_state <= r_run ? S_CDMUL : S_HMUL;
                    end
                end
                S_HMUL: begin
                    r_bear  <= r_z;
                    r_state <= S_HLOAD;
                end
                S_HLOAD: begin
                    r_x     <= $signed({2'b00, horiz_sum[63:32]});
                    r_y     <= r_up;
                    r_run   <= 1'b1;
                    r_state <= S_PRE;
                end
                S_CDMUL: begin
                    r_neg   <= ang_sel[ANG_W-1];
                    r_state <= S_CDRND;
                end
                S_CDRND: begin
                    r_c     <= r_axis ? cd : pan_c;
                    r_state <= r_axis ? S_SMULLO : S_WRAPLO;
                end
                S_WRAPLO: begin
                    if (r_c < NEG_HALF_C) begin
                        r_c <= r_c + FULL_C;
                    end
                    r_state <= S_WRAPHI;
                end
                S_WRAPHI: begin
                    if (r_c > HALF_C) begin
                        r_c <= r_c - FULL_C;
                    end
                    r_state <= S_SMULLO;
                end
                S_SMULLO: begin
                    r_neg   <= r_c[C_W-1];
                    r_cmag  <= c_mag;
                    r_state <= S_SMULHI;
                end
                S_SMULHI: begin
                    r_acc   <= r_prod[41:0];
                    r_state <= S_SACC;
                end
                S_SACC: begin
                    r_t     <= step_total[63:32] + STEP_HALF;
                    r_state <= S_DMUL;
                end
                S_DMUL: begin
                    r_state <= S_DRES;
                end
                S_DRES: begin
                    if (r_axis) begin
                        r_tilt_step <= pos;
                        r_state     <= S_DECIDE;
                    end else begin
                        r_pan_step <= pos;
                        r_axis     <= AXIS_TILT;
                        r_state    <= S_CDMUL;
                    end
                end
                S_DECIDE: begin
                    r_tilt_go <= tilt_go;
                    if (pan_go) begin
                        r_sent_pan  <= r_pan_step;
                        r_pan_known <= 1'b1;
                    end
                    if (tilt_go) begin
                        r_sent_tilt  <= r_tilt_step;
                        r_tilt_known <= 1'b1;
                    end
                    priority if (pan_go) begin
                        r_state <= S_OUTPAN;
                    end else if (tilt_go) begin
                        r_state <= S_OUTTILT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUTPAN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_axis  <= AXIS_PAN;
                        r_out_pos   <= r_pan_step;
                        r_out_last  <= !r_tilt_go;
                        r_state     <= r_tilt_go ? S_OUTTILT : S_IDLE;
                    end
                end
                S_OUTTILT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_axis  <= AXIS_TILT;
                        r_out_pos   <= r_tilt_step;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_axis        = r_out_axis;
    assign o_position    = r_out_pos;
    assign o_last_of_run = r_out_last;

endmodule

[rtl/dpts_checker.sv]
// ----------------------------------------------------------------------------
// dpts_checker - port-level checks for direction_to_pan_tilt_steps_top
// Watches the input and output channels and the order of step commands.
// ----------------------------------------------------------------------------
module dpts_checker
    import dpts_pkg::*;
#(
    parameter int POSITION_BITS = 14
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_ready,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  logic                            o_axis,
    input  logic signed [POSITION_BITS-1:0] o_position,
    input  logic                            o_last_of_run
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_position) && $stable(o_axis)
            && $stable(o_last_of_run))
        else $error("output changed while stalled");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready again straight after an input transfer");

    a_tilt_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_axis == AXIS_TILT) |-> o_last_of_run)
        else $error("tilt command not last of its run");

    a_tilt_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_of_run |=>
            o_out_valid && (o_axis == AXIS_TILT))
        else $error("pan command not followed by tilt");

    a_no_in_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_run |-> !o_in_ready)
        else $error("input taken before the run was complete");

endmodule

bind direction_to_pan_tilt_steps_top dpts_checker #(
    .POSITION_BITS(POSITION_BITS)
) u_dpts_checker (.*);
